/* hdl/assert_macros.svh */
// Assertion macros for the files that check their own logic.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/trs_pkg.sv */
package trs_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int MAX_NODES = 8;
  localparam int REL_W     = 64;
  localparam int VEC_W     = 8;

  typedef logic [REL_W-1:0] rel_t;
  typedef logic [VEC_W-1:0] vec_t;

  // Operation codes carried in the command field.
  typedef enum logic [1:0] {
    CMD_COMBINE = 2'd0,
    CMD_EXTEND  = 2'd1,
    CMD_APPLY   = 2'd2,
    CMD_EQUAL   = 2'd3
  } cmd_t;

  // One operation as held in the input register.
  typedef struct packed {
    cmd_t command;
    rel_t first_rel;
    vec_t first_gen;
    rel_t second_rel;
    vec_t second_gen;
    vec_t in_vector;
  } op_t;

  // One result as held in the output register.
  typedef struct packed {
    rel_t result_rel;
    vec_t result_gen;
    logic is_equal;
  } res_t;

endpackage

/* hdl/trs_in_if.sv */
interface trs_in_if;
  import trs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] command;
  rel_t       first_rel;
  vec_t       first_gen;
  rel_t       second_rel;
  vec_t       second_gen;
  vec_t       in_vector;

  modport source (
    output valid, command, first_rel, first_gen, second_rel, second_gen, in_vector,
    input  ready
  );

  modport sink (
    input  valid, command, first_rel, first_gen, second_rel, second_gen, in_vector,
    output ready
  );
endinterface

/* hdl/trs_out_if.sv */
interface trs_out_if;
  import trs_pkg::*;

  logic valid;
  logic ready;
  rel_t result_rel;
  vec_t result_gen;
  logic is_equal;

  modport source (
    output valid, result_rel, result_gen, is_equal,
    input  ready
  );

  modport sink (
    input  valid, result_rel, result_gen, is_equal,
    output ready
  );
endinterface

/* hdl/trs_map.sv */
// Maps a taint vector through a flow relation: the OR of the rows selected
// by the set bits of the vector.
module trs_map #(
  parameter int NODES = 8
) (
  input  trs_pkg::rel_t rel,
  input  trs_pkg::vec_t vec,
  output trs_pkg::vec_t mapped
);
  import trs_pkg::*;

  localparam vec_t ROW_MASK = vec_t'((1 << NODES) - 1);

  vec_t acc;

  // OR together every selected row, keeping only the meaningful columns.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NODES; i++) begin
      if (vec[i]) begin
        acc = acc | (rel[NODES*i +: VEC_W] & ROW_MASK);
      end
    end
  end

  assign mapped = acc;
endmodule

/* hdl/trs_compute.sv */
// Combinational datapath: combine, extend, apply and equal over one operation.
module trs_compute #(
  parameter int NODES = 8
) (
  input  trs_pkg::op_t  op,
  output trs_pkg::res_t res
);
  import trs_pkg::*;

  localparam vec_t ROW_MASK = vec_t'((1 << NODES) - 1);
  localparam rel_t REL_MASK = (NODES >= MAX_NODES) ? {REL_W{1'b1}} :
                              rel_t'((65'd1 << (NODES*NODES)) - 65'd1);

  rel_t a_rel;
  rel_t b_rel;
  vec_t a_gen;
  vec_t b_gen;
  vec_t vec;
  vec_t gen_src;
  vec_t gen_mapped;
  vec_t ext_rows [NODES];
  rel_t ext_rel;

  // Bits beyond the node count are ignored on input.
  assign a_rel = op.first_rel & REL_MASK;
  assign b_rel = op.second_rel & REL_MASK;
  assign a_gen = op.first_gen & ROW_MASK;
  assign b_gen = op.second_gen & ROW_MASK;
  assign vec   = op.in_vector & ROW_MASK;

  // One mapper per output row of the composed relation.
  for (genvar g = 0; g < NODES; g++) begin : g_row
    trs_map #(.NODES(NODES)) u_row_map (
      .rel    (a_rel),
      .vec    (b_rel[NODES*g +: VEC_W] & ROW_MASK),
      .mapped (ext_rows[g])
    );
  end

  always_comb begin
    ext_rel = '0;
    for (int i = 0; i < NODES; i++) begin
      ext_rel = ext_rel | (rel_t'(ext_rows[i]) << (NODES*i));
    end
  end

  // The gen mapper is shared by extend and apply.
  assign gen_src = (op.command == CMD_APPLY) ? vec : b_gen;

  trs_map #(.NODES(NODES)) u_gen_map (
    .rel    (a_rel),
    .vec    (gen_src),
    .mapped (gen_mapped)
  );

  // Select the result for the operation; unused fields stay zero.
  always_comb begin
    res = '0;
    case (op.command)
      CMD_COMBINE: begin
        res.result_rel = a_rel | b_rel;
        res.result_gen = a_gen | b_gen;
      end
      CMD_EXTEND: begin
        res.result_rel = ext_rel;
        res.result_gen = gen_mapped | a_gen;
      end
      CMD_APPLY: begin
        res.result_gen = gen_mapped | a_gen;
      end
      CMD_EQUAL: begin
        res.is_equal = (a_rel == b_rel) && (a_gen == b_gen);
      end
      default: begin
        res = '0;
      end
    endcase
  end
endmodule

/* hdl/taint_relation_semiring_alu.sv */
// Transfer-function ALU for taint analysis over NODES taint bits.
// Input channel in_chan carries one operation per transaction: a command
// (combine, extend, apply or equal), two transfer functions (relation and
// generated taint each) and a taint vector for apply. Output channel
// out_chan carries exactly one result transaction per operation, in order.
// Both channels use valid/ready; a transaction moves on a rising edge where
// both are high.
// An accepted operation is held in the input register, computed
// combinationally and held again in the output register, which drives out_chan.
// Throughput: one operation per cycle while the receiver does not stall, set by
// the input register, one level of AND-OR logic and the output register.
// When the receiver stalls, the result waits in the output register and the
// input register still holds one more operation; in_chan.ready drops only
// when both are full.
// Reset (rst_n low at a clock edge) empties both registers; nothing is lost
// that was not yet accepted.
module taint_relation_semiring_alu #(
  parameter int NODES = 8
) (
  input logic        clk,
  input logic        rst_n,
  trs_in_if.sink     in_chan,
  trs_out_if.source  out_chan
);
  import trs_pkg::*;

  logic in_valid_r;
  logic in_valid_nxt;
  op_t  in_item_r;
  op_t  in_item_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_item_r;
  res_t comp_res;
  logic out_adv;
  logic in_take;

  // Handshake control: the output register frees when empty or taken.
  assign out_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !in_valid_r || out_adv;
  assign in_take        = in_chan.valid && in_chan.ready;

  assign in_valid_nxt   = in_chan.ready ? in_chan.valid : in_valid_r;
  assign out_valid_nxt  = out_adv ? in_valid_r : out_valid_r;

  assign in_item_nxt = '{
    command:    cmd_t'(in_chan.command),
    first_rel:  in_chan.first_rel,
    first_gen:  in_chan.first_gen,
    second_rel: in_chan.second_rel,
    second_gen: in_chan.second_gen,
    in_vector:  in_chan.in_vector
  };

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item_nxt;
    end
    if (out_adv && in_valid_r) begin
      out_item_r <= comp_res;
    end
  end

  trs_compute #(.NODES(NODES)) u_compute (
    .op  (in_item_r),
    .res (comp_res)
  );

  // Result channel.
  assign out_chan.valid      = out_valid_r;
  assign out_chan.result_rel = out_item_r.result_rel;
  assign out_chan.result_gen = out_item_r.result_gen;
  assign out_chan.is_equal   = out_item_r.is_equal;

  // Checks on the pipeline control and result encoding.
`include "assert_macros.svh"
  `ASSERT_NEXT(a_take_fills, in_take, in_valid_r, "accepted operation not registered")
  `ASSERT_NEXT(a_stage_holds, in_valid_r && !out_adv, in_valid_r && $stable(in_item_r), "held operation changed during stall")
  `ASSERT_NEXT(a_result_holds, out_valid_r && !out_chan.ready, out_valid_r && $stable(out_item_r), "stalled result changed")
  `ASSERT_SAME(a_equal_clean, out_valid_r && out_item_r.is_equal, out_item_r.result_rel == '0 && out_item_r.result_gen == '0, "equal result has nonzero fields")
endmodule

/* bench/taint_relation_semiring_alu_tb.sv */
module taint_relation_semiring_alu_tb;
  import trs_pkg::*;

  localparam int NODES = 8;
  localparam vec_t ROW_MASK = vec_t'((1 << NODES) - 1);
  localparam rel_t IDENTITY_REL = 64'h8040_2010_0804_0201;
  localparam int RANDOM_OPS = 950;
  localparam int CALM_TAIL = 150;
  localparam int STALL_LIMIT = 1000;

  // One row of the directed table: the operation, and a result that is
  // typed in where it is obvious, otherwise left to the predictor.
  typedef struct {
    op_t  op;
    bit   typed_in;
    res_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  trs_in_if  in_chan ();
  trs_out_if out_chan ();

  taint_relation_semiring_alu #(.NODES(NODES)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  res_t      pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        results_checked = 0;
  int        ops_seen[4] = '{0, 0, 0, 0};
  int        idle_cycles = 0;
  bit        allow_idle = 1'b1;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mask of the relation bits that belong to the node count.
  function automatic rel_t live_rel_mask();
    rel_t m;
    m = '0;
    for (int i = 0; i < NODES; i++) m |= rel_t'(ROW_MASK) << (NODES * i);
    return m;
  endfunction

  // Taint reached from vector v through relation rel: OR of the rows selected by v.
  function automatic vec_t taint_image(rel_t rel, vec_t v);
    vec_t acc;
    acc = '0;
    for (int i = 0; i < NODES; i++)
      if (v[i]) acc |= vec_t'((rel >> (NODES * i)) & rel_t'(ROW_MASK));
    return acc;
  endfunction

  // Expected result of one transfer-function operation.
  function automatic res_t predict_transfer(op_t o);
    res_t r;
    rel_t a_rel, b_rel;
    vec_t a_gen, b_gen, vec, row;
    a_rel = o.first_rel & live_rel_mask();
    b_rel = o.second_rel & live_rel_mask();
    a_gen = o.first_gen & ROW_MASK;
    b_gen = o.second_gen & ROW_MASK;
    vec   = o.in_vector & ROW_MASK;
    r = '0;
    case (o.command)
      CMD_COMBINE: begin
        r.result_rel = a_rel | b_rel;
        r.result_gen = a_gen | b_gen;
      end
      CMD_EXTEND: begin
        // Row i of the composition is the first relation applied to row i of the second.
        for (int i = 0; i < NODES; i++) begin
          row = vec_t'((b_rel >> (NODES * i)) & rel_t'(ROW_MASK));
          r.result_rel |= rel_t'(taint_image(a_rel, row)) << (NODES * i);
        end
        r.result_gen = taint_image(a_rel, b_gen) | a_gen;
      end
      CMD_APPLY: begin
        r.result_gen = taint_image(a_rel, vec) | a_gen;
      end
      default: begin
        r.is_equal = (a_rel == b_rel) && (a_gen == b_gen);
      end
    endcase
    return r;
  endfunction

  function automatic op_t mk_op(cmd_t c, rel_t ar, vec_t ag, rel_t br, vec_t bg, vec_t v);
    op_t o;
    o.command    = c;
    o.first_rel  = ar;
    o.first_gen  = ag;
    o.second_rel = br;
    o.second_gen = bg;
    o.in_vector  = v;
    return o;
  endfunction

  function automatic res_t mk_res(rel_t rel, vec_t gen, logic eq);
    res_t r;
    r.result_rel = rel;
    r.result_gen = gen;
    r.is_equal   = eq;
    return r;
  endfunction

  // Relations drawn from a mix of shapes: dense, sparse, identity and extremes.
  function automatic rel_t rand_rel();
    rel_t r;
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = '1;
      2: r = IDENTITY_REL;
      3: r = rel_t'(1) << $urandom_range(0, 63);
      4, 5: r = {$urandom, $urandom} & {$urandom, $urandom};
      default: r = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = vec_t'(1) << $urandom_range(0, 7);
      default: v = vec_t'($urandom);
    endcase
    return v;
  endfunction

  // Random operation; equal mostly compares a copy, exact or with one bit flipped.
  function automatic op_t rand_op();
    op_t o;
    o = mk_op(cmd_t'($urandom_range(0, 3)), rand_rel(), rand_vec(), rand_rel(), rand_vec(),
              rand_vec());
    if (o.command == CMD_EQUAL) begin
      case ($urandom_range(0, 3))
        0: begin
          o.second_rel = o.first_rel;
          o.second_gen = o.first_gen;
        end
        1: begin
          o.second_rel = o.first_rel ^ (rel_t'(1) << $urandom_range(0, 63));
          o.second_gen = o.first_gen;
        end
        2: begin
          o.second_rel = o.first_rel;
          o.second_gen = o.first_gen ^ (vec_t'(1) << $urandom_range(0, 7));
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  function automatic void add_row(op_t o, bit typed_in, res_t want);
    stim_row_t row;
    row.op       = o;
    row.typed_in = typed_in;
    row.want     = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Directed table: extremes of every field, each operation, unused fields and equality cases.
  function automatic void build_directed_table();
    res_t none;
    none = '0;
    add_row(mk_op(CMD_COMBINE, '0, '0, '0, '0, '0), 1, mk_res('0, '0, 1'b0));
    add_row(mk_op(CMD_COMBINE, '1, '1, '1, '1, '1), 1, mk_res('1, '1, 1'b0));
    add_row(mk_op(CMD_COMBINE, '1, '0, '0, '1, '0), 1, mk_res('1, '1, 1'b0));
    add_row(mk_op(CMD_COMBINE, 64'h0123_4567_89ab_cdef, 8'h3c, 64'hf0f0_0f0f_5555_aaaa,
                  8'h81, 8'hff), 0, none);
    add_row(mk_op(CMD_EXTEND, '0, '0, '0, '0, '0), 1, mk_res('0, '0, 1'b0));
    add_row(mk_op(CMD_EXTEND, '1, '0, '1, '1, '0), 1, mk_res('1, '1, 1'b0));
    add_row(mk_op(CMD_EXTEND, IDENTITY_REL, '0, IDENTITY_REL, '0, '0), 1,
            mk_res(IDENTITY_REL, '0, 1'b0));
    add_row(mk_op(CMD_EXTEND, 64'h0123_4567_89ab_cdef, 8'h10, IDENTITY_REL, 8'h42, 8'hff),
            0, none);
    add_row(mk_op(CMD_EXTEND, IDENTITY_REL, 8'h00, 64'hdead_beef_cafe_f00d, 8'h99, 8'h00),
            0, none);
    // A chain 0->1->...->7 composed with itself, with taint generated on node 0.
    add_row(mk_op(CMD_EXTEND, 64'h0080_4020_1008_0402, 8'h00, 64'h0080_4020_1008_0402,
                  8'h01, 8'h00), 0, none);
    add_row(mk_op(CMD_APPLY, '0, '0, '0, '0, '0), 1, mk_res('0, '0, 1'b0));
    add_row(mk_op(CMD_APPLY, '1, '0, '1, '1, '1), 1, mk_res('0, '1, 1'b0));
    add_row(mk_op(CMD_APPLY, IDENTITY_REL, '0, '1, '1, 8'h5a), 1, mk_res('0, 8'h5a, 1'b0));
    add_row(mk_op(CMD_APPLY, '1, 8'ha5, '0, '0, '0), 1, mk_res('0, 8'ha5, 1'b0));
    add_row(mk_op(CMD_APPLY, 64'h8100_0000_0000_00ff, 8'h00, '0, '0, 8'h80), 0, none);
    add_row(mk_op(CMD_EQUAL, '0, '0, '0, '0, '0), 1, mk_res('0, '0, 1'b1));
    add_row(mk_op(CMD_EQUAL, '1, '1, '1, '1, '1), 1, mk_res('0, '0, 1'b1));
    add_row(mk_op(CMD_EQUAL, '1, '1, 64'h7fff_ffff_ffff_ffff, '1, '0), 1,
            mk_res('0, '0, 1'b0));
    add_row(mk_op(CMD_EQUAL, IDENTITY_REL, 8'h01, IDENTITY_REL, 8'h00, '0), 1,
            mk_res('0, '0, 1'b0));
    add_row(mk_op(CMD_EQUAL, 64'h0123_4567_89ab_cdef, 8'h77, 64'h0123_4567_89ab_cdef,
                  8'h77, 8'hff), 0, none);
  endfunction

  // Offer one operation, possibly after an idle burst, and hold it until it is taken.
  task automatic issue_op(op_t o, bit typed_in, res_t want);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.command    <= o.command;
    in_chan.first_rel  <= o.first_rel;
    in_chan.first_gen  <= o.first_gen;
    in_chan.second_rel <= o.second_rel;
    in_chan.second_gen <= o.second_gen;
    in_chan.in_vector  <= o.in_vector;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.insert(pending_results.size(), typed_in ? want : predict_transfer(o));
    ops_seen[int'(o.command)]++;
  endtask

  // Hold off the sender until every outstanding result has been returned.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("Mismatch on %s at result %0d: got %h, expected %h", field, results_checked,
             got, want);
    mismatches++;
  endtask

  // Stimulus: directed table, then random operations, then the closing wait.
  initial begin
    res_t none;
    none = '0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.command    <= CMD_COMBINE;
    in_chan.first_rel  <= '0;
    in_chan.first_gen  <= '0;
    in_chan.second_rel <= '0;
    in_chan.second_gen <= '0;
    in_chan.in_vector  <= '0;
    build_directed_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      issue_op(directed_rows[k].op, directed_rows[k].typed_in, directed_rows[k].want);
    drain_results();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      // A stretch without idling in the middle, and a quiet tail.
      allow_idle = !((n >= 300 && n < 400) || n >= RANDOM_OPS - CALM_TAIL);
      if (n == RANDOM_OPS / 2) drain_results();
      issue_op(rand_op(), 1'b0, none);
    end
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d combine, %0d extend, %0d apply and %0d equal operations,",
             ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
    $display("with %0d results compared under random stalls on both channels.",
             results_checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: ready held high, with random stall bursts while idling is allowed.
  initial begin
    out_chan.ready <= 1'b0;
    repeat (5) @(posedge clk);
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Compare each returned transaction with the oldest outstanding expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_chan.result_rel, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.result_rel !== want.result_rel)
          report_mismatch("result_rel", out_chan.result_rel, want.result_rel);
        if (out_chan.result_gen !== want.result_gen)
          report_mismatch("result_gen", 64'(out_chan.result_gen), 64'(want.result_gen));
        if (out_chan.is_equal !== want.is_equal)
          report_mismatch("is_equal", 64'(out_chan.is_equal), 64'(want.is_equal));
      end
      results_checked++;
    end
  end

  // Watchdog: give up when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/trs_pkg.sv
hdl/trs_in_if.sv
hdl/trs_out_if.sv
hdl/trs_map.sv
hdl/trs_compute.sv
hdl/taint_relation_semiring_alu.sv
bench/taint_relation_semiring_alu_tb.sv
